@@ rtl/token_frequency_table_macros.svh @@
// ----------------------------------------------------------------------------
// token_frequency_table assertion macros
// Shared concurrent assertion forms, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef TOKEN_FREQUENCY_TABLE_MACROS_SVH
`define TOKEN_FREQUENCY_TABLE_MACROS_SVH

// check a property at every clock edge outside reset
`define TFT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that a condition is followed by a consequence in the next cycle
`define TFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tft_pkg.sv @@
// ----------------------------------------------------------------------------
// tft_pkg
// Constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tft_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_WIDTH = 16;

    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W     = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_LO_W   = 64;
    localparam int KEY_HI_W   = 16;
    localparam int KEY_W      = KEY_LO_W + KEY_HI_W;
    localparam int OUT_CNT_W  = 16;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = KEY_W;
    localparam int OUT_DATA_W = KEY_W + OUT_CNT_W;

    localparam logic KIND_COUNT = 1'b0;
    localparam logic KIND_DUMP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_INC   = 3'd0,
        STAT_INS   = 3'd1,
        STAT_FULL  = 3'd2,
        STAT_DUMP  = 3'd3,
        STAT_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_LOOK,
        S_UPD,
        S_SCAN,
        S_KRD,
        S_DEMIT,
        S_DEMPTY
    } t_state;

    typedef struct packed {
        logic load;
        logic cmp;
        logic look;
        logic upd;
        logic dump_start;
        logic scan;
        logic key_rd;
        logic emit_dump;
        logic emit_empty;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic used_zero;
        logic scan_done;
        logic dump_last;
    } t_sts;

    function automatic logic [OUT_CNT_W-1:0] to_out_count(input logic [COUNT_WIDTH-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OUT_CNT_W-1:0];
    endfunction

endpackage

@@ rtl/token_frequency_table.sv @@
// ----------------------------------------------------------------------------
// token_frequency_table - counted table of distinct 10-byte tokens
// Count word: compare, lookup, update (waits for a free result slot); next word taken in idle.
// Dump word: one count scan per entry, an empty word if none; one count memory read port.
// Reset clears the fill count, not the key and count memories; table is empty at once, no clearing pass.
// ----------------------------------------------------------------------------
module token_frequency_table import tft_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // key_low[63:0], key_high[79:64]
    input  logic [0:0]            s_axis_tuser,   // kind[0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // entry_key_low, entry_key_high, entry_count
    output logic [STATUS_W-1:0]   m_axis_tuser,   // status[2:0]
    output logic                  m_axis_tlast
);

    t_cmd                 cmd;
    t_sts                 sts;
    t_status              out_status;
    logic [KEY_LO_W-1:0]  out_key_lo;
    logic [KEY_HI_W-1:0]  out_key_hi;
    logic [OUT_CNT_W-1:0] out_count;

    tft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tft_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key_lo     (s_axis_tdata[KEY_LO_W-1:0]),
        .i_key_hi     (s_axis_tdata[KEY_W-1:KEY_LO_W]),
        .i_out_ready  (m_axis_tready),
        .o_sts        (sts),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (out_status),
        .o_out_key_lo (out_key_lo),
        .o_out_key_hi (out_key_hi),
        .o_out_count  (out_count),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_count, out_key_hi, out_key_lo};
    assign m_axis_tuser = out_status;

endmodule

@@ rtl/tft_ctrl.sv @@
// ----------------------------------------------------------------------------
// tft_ctrl
// Sequencer for count updates and frequency-ordered dumps.
// ----------------------------------------------------------------------------
module tft_ctrl import tft_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_kind,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_DUMP) begin
                        n_state = i_sts.used_zero ? S_DEMPTY : S_SCAN;
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP:  n_state = S_LOOK;
            S_LOOK: n_state = S_UPD;
            S_UPD: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.scan_done) n_state = S_KRD;
            end
            S_KRD:  n_state = S_DEMIT;
            S_DEMIT: begin
                if (i_sts.out_free) n_state = i_sts.dump_last ? S_IDLE : S_SCAN;
            end
            S_DEMPTY: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready       = i_rst_n;
                o_cmd.load       = i_in_valid;
                o_cmd.dump_start = i_in_valid && (i_in_kind == KIND_DUMP);
            end
            S_CMP:    o_cmd.cmp        = 1'b1;
            S_LOOK:   o_cmd.look       = 1'b1;
            S_UPD:    o_cmd.upd        = i_sts.out_free;
            S_SCAN:   o_cmd.scan       = 1'b1;
            S_KRD:    o_cmd.key_rd     = 1'b1;
            S_DEMIT:  o_cmd.emit_dump  = i_sts.out_free;
            S_DEMPTY: o_cmd.emit_empty = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/tft_dpath.sv @@
// ----------------------------------------------------------------------------
// tft_dpath
// Key compare array, key and count memories, dump selection and result word.
// ----------------------------------------------------------------------------
`include "token_frequency_table_macros.svh"

module tft_dpath import tft_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [KEY_LO_W-1:0]  i_key_lo,
    input  logic [KEY_HI_W-1:0]  i_key_hi,
    input  logic                 i_out_ready,
    output t_sts                 o_sts,
    output logic                 o_out_valid,
    output t_status              o_out_status,
    output logic [KEY_LO_W-1:0]  o_out_key_lo,
    output logic [KEY_HI_W-1:0]  o_out_key_hi,
    output logic [OUT_CNT_W-1:0] o_out_count,
    output logic                 o_out_last
);

    logic [KEY_LO_W-1:0]    r_key_lo;
    logic [KEY_HI_W-1:0]    r_key_hi;
    logic [KEY_LO_W-1:0]    r_cam_lo [TABLE_DEPTH];
    logic [KEY_HI_W-1:0]    r_cam_hi [TABLE_DEPTH];
    logic [KEY_W-1:0]       r_kmem   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] r_cmem   [TABLE_DEPTH];

    logic [USED_W-1:0]      r_used;
    logic [TABLE_DEPTH-1:0] r_hit;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       n_idx;
    logic                   r_any_hit;
    logic [COUNT_WIDTH-1:0] r_cnt_rd;

    logic [USED_W-1:0]      r_scan;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_rd_idx;
    logic [COUNT_WIDTH-1:0] r_best_cnt;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   r_found;
    logic [COUNT_WIDTH-1:0] r_prev_cnt;
    logic [IDX_W-1:0]       r_prev_idx;
    logic                   r_first;
    logic [USED_W-1:0]      r_rank;
    logic [KEY_W-1:0]       r_kd;

    logic                   r_out_vld;
    t_status                r_out_status;
    logic [KEY_LO_W-1:0]    r_out_key_lo;
    logic [KEY_HI_W-1:0]    r_out_key_hi;
    logic [OUT_CNT_W-1:0]   r_out_count;
    logic                   r_out_last;

    logic                   full;
    logic                   do_ins;
    logic [IDX_W-1:0]       ins_idx;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   scan_issue;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   cmem_we;
    logic [IDX_W-1:0]       cmem_wa;
    logic [COUNT_WIDTH-1:0] cmem_wd;
    logic                   elig;
    logic                   better;
    logic                   dump_last;

    always_comb begin
        n_idx = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (r_hit[i]) n_idx = n_idx | IDX_W'(i);
        end
    end

    assign full       = (r_used == USED_W'(TABLE_DEPTH));
    assign ins_idx    = r_used[IDX_W-1:0];
    assign do_ins     = i_cmd.upd && !r_any_hit && !full;
    assign cnt_inc    = (r_cnt_rd == {COUNT_WIDTH{1'b1}}) ? r_cnt_rd
                                                          : r_cnt_rd + COUNT_WIDTH'(1);
    assign scan_issue = i_cmd.scan && (r_scan < r_used);
    assign rd_en      = i_cmd.look || scan_issue;
    assign rd_addr    = i_cmd.look ? n_idx : r_scan[IDX_W-1:0];
    assign cmem_we    = (i_cmd.upd && r_any_hit) || do_ins;
    assign cmem_wa    = r_any_hit ? r_idx : ins_idx;
    assign cmem_wd    = r_any_hit ? cnt_inc : COUNT_WIDTH'(1);
    assign elig       = r_first || (r_cnt_rd < r_prev_cnt) ||
                        ((r_cnt_rd == r_prev_cnt) && (r_rd_idx > r_prev_idx));
    assign better     = !r_found || (r_cnt_rd > r_best_cnt);
    assign dump_last  = ((r_rank + USED_W'(1)) == r_used);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_lo <= i_key_lo;
            r_key_hi <= i_key_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (do_ins && (ins_idx == IDX_W'(i))) begin
                r_cam_lo[i] <= r_key_lo;
                r_cam_hi[i] <= r_key_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= '0;
        end else if (i_cmd.cmp) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_hit[i] <= (r_cam_lo[i] == r_key_lo) && (r_cam_hi[i] == r_key_hi) &&
                            (USED_W'(i) < r_used);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_idx     <= n_idx;
            r_any_hit <= |r_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmem_we) r_cmem[cmem_wa] <= cmem_wd;
        if (rd_en) r_cnt_rd <= r_cmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (do_ins) r_kmem[ins_idx] <= {r_key_hi, r_key_lo};
        if (i_cmd.key_rd) r_kd <= r_kmem[r_best_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (do_ins) begin
            r_used <= r_used + USED_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_first  <= 1'b1;
            r_rank   <= '0;
        end else if (i_cmd.dump_start || i_cmd.emit_dump) begin
            r_scan   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            if (i_cmd.dump_start) begin
                r_first <= 1'b1;
                r_rank  <= '0;
            end else begin
                r_first    <= 1'b0;
                r_rank     <= r_rank + USED_W'(1);
                r_prev_cnt <= r_best_cnt;
                r_prev_idx <= r_best_idx;
            end
        end else begin
            r_rd_vld <= scan_issue;
            if (scan_issue) begin
                r_scan   <= r_scan + USED_W'(1);
                r_rd_idx <= r_scan[IDX_W-1:0];
            end
            if (r_rd_vld && elig && better) begin
                r_found    <= 1'b1;
                r_best_cnt <= r_cnt_rd;
                r_best_idx <= r_rd_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.upd || i_cmd.emit_dump || i_cmd.emit_empty) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_out_key_lo <= r_key_lo;
            r_out_key_hi <= r_key_hi;
            r_out_last   <= 1'b1;
            if (r_any_hit) begin
                r_out_status <= STAT_INC;
                r_out_count  <= to_out_count(cnt_inc);
            end else if (full) begin
                r_out_status <= STAT_FULL;
                r_out_count  <= '0;
            end else begin
                r_out_status <= STAT_INS;
                r_out_count  <= to_out_count(COUNT_WIDTH'(1));
            end
        end else if (i_cmd.emit_dump) begin
            r_out_status <= STAT_DUMP;
            r_out_key_lo <= r_kd[KEY_LO_W-1:0];
            r_out_key_hi <= r_kd[KEY_W-1:KEY_LO_W];
            r_out_count  <= to_out_count(r_best_cnt);
            r_out_last   <= dump_last;
        end else if (i_cmd.emit_empty) begin
            r_out_status <= STAT_EMPTY;
            r_out_key_lo <= '0;
            r_out_key_hi <= '0;
            r_out_count  <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_sts.out_free  = !r_out_vld || i_out_ready;
    assign o_sts.used_zero = (r_used == '0);
    assign o_sts.scan_done = (r_scan == r_used) && !r_rd_vld;
    assign o_sts.dump_last = dump_last;

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_key_lo = r_out_key_lo;
    assign o_out_key_hi = r_out_key_hi;
    assign o_out_count  = r_out_count;
    assign o_out_last   = r_out_last;

    `TFT_ASSERT(a_hit_unique, i_clk, i_rst_n, $onehot0(r_hit), "stored keys not distinct")
    `TFT_ASSERT(a_used_range, i_clk, i_rst_n, r_used <= USED_W'(TABLE_DEPTH), "fill count overflow")
    `TFT_ASSERT(a_emit_found, i_clk, i_rst_n, i_cmd.emit_dump |-> r_found, "dump word without entry")
    `TFT_ASSERT(a_upd_slot, i_clk, i_rst_n, i_cmd.upd |-> (!r_out_vld || i_out_ready), "result overrun")
    `TFT_ASSERT_NEXT(a_ins_grow, i_clk, i_rst_n, do_ins, r_used == $past(r_used) + USED_W'(1), "insert lost")

endmodule
